/* rtl/mdpn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdpn_pkg
// Shared widths, codes and handshake structs of the mono downmix peak
// normalizer.
// ----------------------------------------------------------------------------
package mdpn_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int ACC_W           = 19;
    localparam int CC_W            = 4;
    localparam int POS_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int MAX_CHANNELS    = 8;
    localparam int STORE_DEPTH_DEF = 4096;

    // The shared divider handles both the frame average and the peak scaling.
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;

    localparam logic [CC_W-1:0] CC_RESET = CC_W'(1);

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PAST_END = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OK_OVF   = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/mdpn_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdpn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mdpn_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mdpn_pkg::div_req_t req,
    output mdpn_pkg::div_rsp_t     rsp
);

    localparam int NUM_W = mdpn_pkg::DIV_NUM_W;
    localparam int DEN_W = mdpn_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   partial;
    logic             fits;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        partial = {rem_reg, quo_reg[NUM_W-1]};
        fits    = partial >= {1'b0, den_reg};
        diff    = partial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= '0;
                quo_reg <= req.dividend;
                den_reg <= req.divisor;
            end
            else if (run_reg)
            begin
                rem_reg <= fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp = '{done: done_reg, quotient: quo_reg};

endmodule
`default_nettype wire

/* rtl/mdpn_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdpn_store
// Single-port-write, registered-read sample memory for the mono values.
// ----------------------------------------------------------------------------
module mdpn_store #(
    parameter int DEPTH = mdpn_pkg::STORE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [mdpn_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [mdpn_pkg::SAMPLE_W-1:0] rd_data
);

    logic [mdpn_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/mono_downmix_peak_normalizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Push that does not close a frame: busy stays low, so the next item can
// follow without waiting. Push that closes a frame: busy through the divider
// request, 32 divider steps and store write, then the next item is taken.
// Fetch of an empty store or past the end: result in the cycle after start.
// Other fetches: busy through memory read, divider request, 32 steps, result
// capture (no divider if min equals max), strobe next; not stallable. Reset
// clears control state and sets channel_count to 1; memory needs no clearing.
// ----------------------------------------------------------------------------
// mono_downmix_peak_normalizer
// Downmixes interleaved PCM to mono, stores it and returns it with DC removed
// and the peak scaled to full range.
// ----------------------------------------------------------------------------
module mono_downmix_peak_normalizer #(
    parameter int STORE_DEPTH = mdpn_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 operation,
    input  wire logic signed [mdpn_pkg::SAMPLE_W-1:0] pcm_sample,
    output logic                                      done,
    output logic signed      [mdpn_pkg::SAMPLE_W-1:0] normalized_sample,
    output logic             [mdpn_pkg::STATUS_W-1:0] status,
    output logic                                      last_sample,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [mdpn_pkg::CC_W-1:0]     cfg_data
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CW    = $clog2(STORE_DEPTH + 1);
    localparam int SW    = mdpn_pkg::SAMPLE_W;
    localparam int ACC_W = mdpn_pkg::ACC_W;
    localparam int POS_W = mdpn_pkg::POS_W;
    localparam int CC_W  = mdpn_pkg::CC_W;
    localparam int NUM_W = mdpn_pkg::DIV_NUM_W;
    localparam int DEN_W = mdpn_pkg::DIV_DEN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_AVG_DIV,
        S_FETCH_RD,
        S_NORM_DIV
    } state_t;

    state_t                       state_reg, state_next;
    logic [CC_W-1:0]              cc_reg, cc_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                rdpos_reg, rdpos_next;
    logic signed [SW-1:0]         min_reg, min_next;
    logic signed [SW-1:0]         max_reg, max_next;
    logic                         ovf_reg, ovf_next;
    logic                         reading_reg, reading_next;
    logic                         neg_reg, neg_next;
    mdpn_pkg::div_req_t           div_req_reg, div_req_next;
    logic                         done_reg, done_next;
    logic signed [SW-1:0]         sample_reg, sample_next;
    logic [mdpn_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         last_reg, last_next;

    mdpn_pkg::div_rsp_t           div_rsp;

    logic                         mem_wr_en;
    logic                         mem_rd_en;
    logic [SW-1:0]                mem_rd_data;
    logic signed [SW-1:0]         mono;

    logic                         accept;
    logic [CC_W-1:0]              frame_n;
    logic signed [ACC_W-1:0]      base_acc;
    logic [POS_W-1:0]             base_pos;
    logic signed [ACC_W-1:0]      sum_acc;
    logic [POS_W:0]               sum_pos;
    logic [ACC_W-1:0]             acc_mag;

    logic signed [SW-1:0]         x_val;
    logic signed [SW+2:0]         dev;
    logic [SW+2:0]                dev_mag;
    logic [DEN_W-1:0]             span;
    logic [SW-1:0]                q_low;
    logic signed [SW-1:0]         norm_val;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    // A register write never shares an edge with an item beat.
    assign cfg_ready = (state_reg == S_IDLE) && !start;

    always_comb
    begin
        if (cc_reg == '0)
        begin
            frame_n = CC_W'(1);
        end
        else if (cc_reg > CC_W'(mdpn_pkg::MAX_CHANNELS))
        begin
            frame_n = CC_W'(mdpn_pkg::MAX_CHANNELS);
        end
        else
        begin
            frame_n = cc_reg;
        end

        base_acc = reading_reg ? '0 : acc_reg;
        base_pos = reading_reg ? '0 : pos_reg;
        sum_acc  = base_acc + ACC_W'(pcm_sample);
        sum_pos  = {1'b0, base_pos} + (POS_W + 1)'(1);
        acc_mag  = sum_acc[ACC_W-1] ? ACC_W'(-sum_acc) : ACC_W'(sum_acc);

        q_low = div_rsp.quotient[SW-1:0];
        mono  = neg_reg ? SW'(-q_low) : SW'(q_low);

        // DC offset sits at the min/max midpoint, so 2x - min - max is twice
        // the deviation and span = max - min is twice the peak.
        x_val   = mem_rd_data;
        dev     = {{2{x_val[SW-1]}}, x_val, 1'b0}
                - {{3{min_reg[SW-1]}}, min_reg}
                - {{3{max_reg[SW-1]}}, max_reg};
        dev_mag = dev[SW+2] ? (SW + 3)'(-dev) : (SW + 3)'(dev);
        span    = {max_reg[SW-1], max_reg} - {min_reg[SW-1], min_reg};

        if (neg_reg)
        begin
            norm_val = SW'(-q_low);
        end
        else if (div_rsp.quotient[NUM_W-1:SW-1] != '0)
        begin
            norm_val = {1'b0, {(SW - 1){1'b1}}};
        end
        else
        begin
            norm_val = SW'(q_low);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cc_next      = cc_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        rdpos_next   = rdpos_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        ovf_next     = ovf_reg;
        reading_next = reading_reg;
        neg_next     = neg_reg;
        div_req_next = div_req_reg;
        div_req_next.start = 1'b0;
        done_next    = 1'b0;
        sample_next  = sample_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == mdpn_pkg::OP_PUSH)
                begin
                    if (reading_reg)
                    begin
                        count_next   = '0;
                        rdpos_next   = '0;
                        min_next     = {1'b0, {(SW - 1){1'b1}}};
                        max_next     = {1'b1, {(SW - 1){1'b0}}};
                        ovf_next     = 1'b0;
                        reading_next = 1'b0;
                    end
                    if (sum_pos >= (POS_W + 1)'(frame_n))
                    begin
                        acc_next              = '0;
                        pos_next              = '0;
                        neg_next              = sum_acc[ACC_W-1];
                        div_req_next.start    = 1'b1;
                        div_req_next.dividend = NUM_W'(acc_mag);
                        div_req_next.divisor  = DEN_W'(frame_n);
                        state_next            = S_AVG_DIV;
                    end
                    else
                    begin
                        acc_next = sum_acc;
                        pos_next = sum_pos[POS_W-1:0];
                    end
                end
                else if (accept)
                begin
                    reading_next = 1'b1;
                    acc_next     = '0;
                    pos_next     = '0;
                    if (count_reg == '0)
                    begin
                        sample_next = '0;
                        status_next = mdpn_pkg::STATUS_EMPTY;
                        last_next   = 1'b0;
                        done_next   = 1'b1;
                    end
                    else if (rdpos_reg >= count_reg)
                    begin
                        sample_next = '0;
                        status_next = mdpn_pkg::STATUS_PAST_END;
                        last_next   = 1'b0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        mem_rd_en  = 1'b1;
                        state_next = S_FETCH_RD;
                    end
                end
            end

            S_AVG_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (count_reg < CW'(STORE_DEPTH))
                    begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (mono < min_reg)
                        begin
                            min_next = mono;
                        end
                        if (mono > max_reg)
                        begin
                            max_next = mono;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_FETCH_RD:
            begin
                if (span == '0)
                begin
                    sample_next = '0;
                    status_next = ovf_reg ? mdpn_pkg::STATUS_OK_OVF : mdpn_pkg::STATUS_OK;
                    last_next   = (rdpos_reg + CW'(1)) == count_reg;
                    rdpos_next  = rdpos_reg + CW'(1);
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // Stored values lie within [min, max], so the deviation
                    // fits in 17 bits and the shifted dividend in 32.
                    neg_next              = dev[SW+2];
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = {dev_mag[DEN_W-1:0], {(NUM_W - DEN_W){1'b0}}};
                    div_req_next.divisor  = span;
                    state_next            = S_NORM_DIV;
                end
            end

            S_NORM_DIV:
            begin
                if (div_rsp.done)
                begin
                    sample_next = norm_val;
                    status_next = ovf_reg ? mdpn_pkg::STATUS_OK_OVF : mdpn_pkg::STATUS_OK;
                    last_next   = (rdpos_reg + CW'(1)) == count_reg;
                    rdpos_next  = rdpos_reg + CW'(1);
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A register write drops any partial frame in progress.
        if (cfg_valid && cfg_ready)
        begin
            cc_next  = cfg_data;
            acc_next = '0;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cc_reg      <= mdpn_pkg::CC_RESET;
            acc_reg     <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            rdpos_reg   <= '0;
            min_reg     <= {1'b0, {(SW - 1){1'b1}}};
            max_reg     <= {1'b1, {(SW - 1){1'b0}}};
            ovf_reg     <= 1'b0;
            reading_reg <= 1'b0;
            neg_reg     <= 1'b0;
            div_req_reg <= '0;
            done_reg    <= 1'b0;
            sample_reg  <= '0;
            status_reg  <= mdpn_pkg::STATUS_OK;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cc_reg      <= cc_next;
            acc_reg     <= acc_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            rdpos_reg   <= rdpos_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            ovf_reg     <= ovf_next;
            reading_reg <= reading_next;
            neg_reg     <= neg_next;
            div_req_reg <= div_req_next;
            done_reg    <= done_next;
            sample_reg  <= sample_next;
            status_reg  <= status_next;
            last_reg    <= last_next;
        end
    end

    assign done              = done_reg;
    assign normalized_sample = sample_reg;
    assign status            = status_reg;
    assign last_sample       = last_reg;

    mdpn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    mdpn_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (mono),
        .rd_en   (mem_rd_en),
        .rd_addr (rdpos_reg[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("stored count exceeds store depth");

    a_rdpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rdpos_reg <= count_reg)
        else $error("read position beyond stored count");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    a_done_reading: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> reading_reg)
        else $error("result beat outside the reading phase");

endmodule
`default_nettype wire
